### rtl/mlfd_pkg.sv
// Shared constants and types for the sync word, length-prefixed frame deframer.
package mlfd_pkg;

    localparam int BUF_BYTES_DEF    = 1024;
    localparam int HEADER_BYTES_DEF = 16;

    localparam int SYNC_LEN    = 4;
    localparam int LEN_OFFSET  = 12;
    localparam int FRAME_LEN_W = 11;
    localparam int BYTE_W      = 8;
    localparam int LOW_LEN_W   = 24;

    localparam logic [BYTE_W-1:0] SYNC_WORD [SYNC_LEN] = '{8'h53, 8'h51, 8'h44, 8'h50};

    typedef enum logic [1:0] {
        STATUS_COLLECT   = 2'd0,
        STATUS_COMPLETE  = 2'd1,
        STATUS_LEN_ERROR = 2'd2
    } status_t;

endpackage

### rtl/magic_length_frame_deframer.sv
// Byte-stream deframer that finds a sync word and tracks a length-prefixed frame.
//
// Usage: each input request on in_valid/in_ready carries one received byte on rx_byte.
// Every byte produces exactly one output request on out_valid/out_ready with a
// status code (collecting, frame complete, length error) and frame_len, the number
// of bytes held after that byte, so a consumer can store the byte at frame_len-1.
// The block hunts for the four-byte sync word; a mismatch in the sync word restarts
// the frame. Header bytes 12 to 15 give the little-endian payload length, and a
// frame whose header plus payload exceeds BUF_BYTES is dropped with a length error.
// A byte accepted enters the input register; its result is then registered in the
// result register when that is empty or being read. Throughput: one byte per cycle
// while out_ready stays high, set by the frame counter update between the two registers.
// Stall: while out_ready is low the result register holds, the input register takes
// one more byte, and in_ready then stays low until the result is taken.
// Reset: all framing state clears to hunting with an empty frame and both the input
// and result registers empty.
module magic_length_frame_deframer #(
    parameter int BUF_BYTES    = mlfd_pkg::BUF_BYTES_DEF,
    parameter int HEADER_BYTES = mlfd_pkg::HEADER_BYTES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [mlfd_pkg::BYTE_W-1:0]      rx_byte,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [1:0]                       status,
    output logic [mlfd_pkg::FRAME_LEN_W-1:0] frame_len
);

    localparam int CW = $clog2(BUF_BYTES + 1);
    localparam int FW = mlfd_pkg::FRAME_LEN_W;
    localparam logic [31:0] MAX_PAYLOAD = 32'(BUF_BYTES - HEADER_BYTES);

    logic                            s1_valid_reg;
    logic [mlfd_pkg::BYTE_W-1:0]     s1_byte_reg;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    mlfd_pkg::status_t               status_reg;
    mlfd_pkg::status_t               status_next;
    logic [FW-1:0]                   frame_len_reg;
    logic [FW-1:0]                   frame_len_next;
    logic [CW-1:0]                   held_reg;
    logic [CW-1:0]                   held_next;
    logic [CW-1:0]                   target_reg;
    logic [CW-1:0]                   target_next;
    logic [mlfd_pkg::LOW_LEN_W-1:0]  low_reg;
    logic [mlfd_pkg::LOW_LEN_W-1:0]  low_next;
    logic [mlfd_pkg::BYTE_W-1:0]     top_reg;
    logic [mlfd_pkg::BYTE_W-1:0]     top_next;

    logic                            advance;
    logic [CW-1:0]                   pos;
    logic                            hunt;
    logic                            sync_ok;
    logic [CW-1:0]                   held_step;
    logic [31:0]                     payload;
    logic [CW-1:0]                   target_step;
    logic [FW+CW-1:0]                flen_wide;

    assign advance   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign frame_len = frame_len_reg;

    assign pos     = held_reg;
    assign hunt    = pos < CW'(mlfd_pkg::SYNC_LEN);
    assign sync_ok = s1_byte_reg == mlfd_pkg::SYNC_WORD[pos[1:0]];

    always_comb
    begin
        held_next      = held_reg;
        target_next    = target_reg;
        low_next       = low_reg;
        top_next       = top_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        frame_len_next = frame_len_reg;
        held_step      = pos + CW'(1);
        payload        = '0;
        target_step    = target_reg;
        flen_wide      = '0;

        if (advance)
        begin
            out_valid_next = 1'b1;
            if (pos >= CW'(BUF_BYTES))
            begin
                held_next      = '0;
                target_next    = '0;
                low_next       = '0;
                top_next       = '0;
                status_next    = mlfd_pkg::STATUS_LEN_ERROR;
                frame_len_next = '0;
            end
            else
            begin
                if (hunt && !sync_ok)
                begin
                    held_step = (s1_byte_reg == mlfd_pkg::SYNC_WORD[0]) ? CW'(1) : CW'(0);
                    low_next  = '0;
                    top_next  = '0;
                    target_step = '0;
                end
                else if (!hunt && pos >= CW'(mlfd_pkg::LEN_OFFSET)
                         && pos < CW'(mlfd_pkg::LEN_OFFSET + 3))
                begin
                    case (pos[1:0])
                        2'd0:    low_next[7:0]   = s1_byte_reg;
                        2'd1:    low_next[15:8]  = s1_byte_reg;
                        2'd2:    low_next[23:16] = s1_byte_reg;
                        default: low_next        = low_reg;
                    endcase
                end

                if (held_step == CW'(mlfd_pkg::LEN_OFFSET + 4)
                    && held_step < CW'(HEADER_BYTES))
                begin
                    top_next = s1_byte_reg;
                end

                flen_wide = {{FW{1'b0}}, held_step};
                if (held_step == CW'(HEADER_BYTES))
                begin
                    payload = {(pos == CW'(mlfd_pkg::LEN_OFFSET + 3)) ? s1_byte_reg : top_reg,
                               low_reg};
                    target_step = CW'(HEADER_BYTES) + payload[CW-1:0];
                end

                if (held_step == CW'(HEADER_BYTES) && payload > MAX_PAYLOAD)
                begin
                    held_next      = '0;
                    target_next    = '0;
                    low_next       = '0;
                    top_next       = '0;
                    status_next    = mlfd_pkg::STATUS_LEN_ERROR;
                    frame_len_next = '0;
                end
                else if (held_step >= CW'(HEADER_BYTES) && target_step != '0
                         && held_step >= target_step)
                begin
                    held_next      = '0;
                    target_next    = '0;
                    low_next       = '0;
                    top_next       = '0;
                    status_next    = mlfd_pkg::STATUS_COMPLETE;
                    frame_len_next = flen_wide[FW-1:0];
                end
                else
                begin
                    held_next      = held_step;
                    target_next    = target_step;
                    status_next    = mlfd_pkg::STATUS_COLLECT;
                    frame_len_next = flen_wide[FW-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            held_reg      <= '0;
            target_reg    <= '0;
            low_reg       <= '0;
            top_reg       <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            out_valid_reg <= out_valid_next;
            held_reg      <= held_next;
            target_reg    <= target_next;
            low_reg       <= low_next;
            top_reg       <= top_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_byte_reg <= rx_byte;
        end
        status_reg    <= status_next;
        frame_len_reg <= frame_len_next;
    end

    // A dropped frame always reports an empty length.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == mlfd_pkg::STATUS_LEN_ERROR) |-> frame_len == '0)
        else $error("length error reported with nonzero frame length");

    // Once the header is complete the frame length must be known.
    assert property (@(posedge clk) disable iff (!rst_n)
        (held_reg >= CW'(HEADER_BYTES)) |-> target_reg != '0)
        else $error("header held without a known frame length");

    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && status_next == mlfd_pkg::STATUS_COMPLETE) |=> held_reg == '0)
        else $error("frame not cleared after completion");

    assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= CW'(BUF_BYTES))
        else $error("held count beyond buffer size");

    assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> in_ready)
        else $error("input stalled with an empty input register");

endmodule
